// ===== hdl/fpts_pkg.sv =====
package fpts_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned MAX_TASKS = 16;
  localparam int unsigned SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W     = SLOT_W + 1;

  localparam int unsigned TASK_ID_W = 4;
  localparam int unsigned ORDER_W   = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned WORK_W    = 16;
  localparam int unsigned PRIO_W    = 8;

  localparam logic [ORDER_W-1:0] ORDER_MAX = {ORDER_W{1'b1}};
  localparam logic [TIME_W-1:0]  CLOCK_MAX = {TIME_W{1'b1}};

  // Function codes of an input item.
  localparam logic FUNC_CREATE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [WORK_W-1:0] run_length;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] release_time;
  } fpts_req_t;

  typedef struct packed {
    logic                 kind;
    logic                 accepted;
    logic [TASK_ID_W-1:0] task_id;
    logic                 idle;
    logic [TIME_W-1:0]    now;
    logic [WORK_W-1:0]    left;
    logic [WORK_W-1:0]    consumed;
  } fpts_rsp_t;

  // One task table entry as it is kept in the slot memory. The order field
  // holds the ready-order value at the time the task became ready; tasks that
  // were woken in the same tick share it and are told apart by release
  // time, then by slot.
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  release_time;
    logic [WORK_W-1:0]  left;
    logic [WORK_W-1:0]  consumed;
    logic [ORDER_W-1:0] order;
  } fpts_entry_t;

  localparam int unsigned ENTRY_W = $bits(fpts_entry_t);

  typedef struct packed {
    logic clear;
    logic cand;
  } fpts_pick_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } fpts_state_e;

endpackage

// ===== hdl/fpts_ram.sv =====
module fpts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fpts_pick.sv =====
module fpts_pick import fpts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpts_pick_ctrl_t   ctrl_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  fpts_entry_t       entry_i,
  output logic              found_o,
  output logic [SLOT_W-1:0] slot_o,
  output fpts_entry_t       entry_o
);

  logic              found_q, found_d;
  logic [SLOT_W-1:0] slot_q;
  fpts_entry_t       best_q;
  logic              better;
  logic              take;

  // Higher priority wins; on equal priority the task that became ready
  // earlier wins. Slots arrive in ascending order, so a full tie keeps the
  // lower slot.
  always_comb begin
    better = !found_q
           || (entry_i.prio > best_q.prio)
           || ((entry_i.prio == best_q.prio)
               && ({entry_i.order, entry_i.release_time}
                   < {best_q.order, best_q.release_time}));
    take    = ctrl_i.cand && !ctrl_i.clear && better;
    found_d = ctrl_i.clear ? 1'b0 : (found_q || take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q <= slot_i;
      best_q <= entry_i;
    end
  end

  assign found_o = found_q;
  assign slot_o  = slot_q;
  assign entry_o = best_q;

endmodule

// ===== hdl/fixed_priority_task_scheduler.sv =====
// Channel    Ports                      Direction  Transfer
// request    start_i, busy_o, req_i     in         start_i high while busy_o low
// result     done_o, rsp_o              out        done_o high for one cycle
//
// A create item's result shows in the next cycle, and busy_o stays low, so items
// can follow back to back.
// A tick item keeps busy_o high for one pass through the slot memory, one entry a
// cycle, and then a write-back state; its result shows in the cycle after the
// write-back, while a new item can already be taken. After reset the table is
// empty and the clock is zero; no clearing pass is needed. The receiver cannot
// stall: every result is transferred on the cycle done_o is high.

module fixed_priority_task_scheduler import fpts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  fpts_req_t req_i,
  output logic      done_o,
  output fpts_rsp_t rsp_o
);

  // Control state. Slots fill from the bottom and are never freed, so a fill
  // count stands for the used flags; the ready flags live in flip-flops.
  fpts_state_e        state_q, state_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]   used_cnt_q, used_cnt_d;
  logic [CNT_W-1:0]   woken_q, woken_d;
  logic [MAX_TASKS-1:0] ready_q, ready_d;
  logic [TIME_W-1:0]  clock_q, clock_d;
  logic [ORDER_W-1:0] next_order_q, next_order_d;
  logic               done_q, done_d;
  fpts_rsp_t          rsp_q, rsp_d;

  // Slot memory ports.
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  fpts_entry_t       mem_wdata;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  fpts_entry_t       rd_entry;

  // Candidate tracker.
  fpts_pick_ctrl_t   pick_ctrl;
  fpts_entry_t       scan_entry;
  logic              pick_found;
  logic [SLOT_W-1:0] pick_slot;
  fpts_entry_t       pick_entry;

  // Helpers.
  logic               accept;
  logic               last_slot;
  logic               slot_used;
  logic               wake;
  logic               full;
  logic [ORDER_W:0]   order_sum;
  fpts_entry_t        new_entry;

  assign rd_entry = fpts_entry_t'(mem_rdata);

  fpts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (ENTRY_W'(mem_wdata)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fpts_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pick_ctrl),
    .slot_i  (idx_q),
    .entry_i (scan_entry),
    .found_o (pick_found),
    .slot_o  (pick_slot),
    .entry_o (pick_entry)
  );

  always_comb begin
    accept    = start_i && (state_q == ST_IDLE);
    last_slot = (idx_q == SLOT_W'(MAX_TASKS - 1));
    slot_used = ({1'b0, idx_q} < used_cnt_q);
    full      = (used_cnt_q == CNT_W'(MAX_TASKS));

    // A waiting task wakes when the scan finds the clock at or past its
    // release time. All tasks woken in one tick share the current order
    // value, so they rank after every task that was ready before.
    wake = slot_used && !ready_q[idx_q] && (rd_entry.release_time <= clock_q);

    scan_entry = rd_entry;
    if (wake) begin
      scan_entry.order = next_order_q;
    end

    new_entry.prio         = req_i.prio;
    new_entry.release_time = req_i.release_time;
    new_entry.left         = req_i.run_length;
    new_entry.consumed     = '0;
    new_entry.order        = (req_i.release_time == '0) ? next_order_q : '0;

    order_sum = {1'b0, next_order_q} + (ORDER_W + 1)'(woken_q);

    state_d      = state_q;
    idx_d        = idx_q;
    used_cnt_d   = used_cnt_q;
    woken_d      = woken_q;
    ready_d      = ready_q;
    clock_d      = clock_q;
    next_order_d = next_order_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;

    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = scan_entry;
    mem_re    = 1'b0;
    mem_raddr = idx_q + SLOT_W'(1);

    pick_ctrl.clear = 1'b0;
    pick_ctrl.cand  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_CREATE) begin
            // Store the task in the lowest free slot and answer at once.
            rsp_d.kind     = FUNC_CREATE;
            rsp_d.accepted = !full;
            rsp_d.task_id  = full ? '0 : TASK_ID_W'(used_cnt_q[SLOT_W-1:0]);
            rsp_d.idle     = 1'b0;
            rsp_d.now      = clock_q;
            rsp_d.left     = full ? '0 : req_i.run_length;
            rsp_d.consumed = '0;
            done_d         = 1'b1;
            if (!full) begin
              mem_we     = 1'b1;
              mem_waddr  = used_cnt_q[SLOT_W-1:0];
              mem_wdata  = new_entry;
              used_cnt_d = used_cnt_q + CNT_W'(1);
              ready_d[used_cnt_q[SLOT_W-1:0]] = (req_i.release_time == '0);
              if ((req_i.release_time == '0) && (next_order_q != ORDER_MAX)) begin
                next_order_d = next_order_q + ORDER_W'(1);
              end
            end
          end else begin
            // Start the scan: slot zero is read now and shows next cycle.
            mem_re          = 1'b1;
            mem_raddr       = '0;
            idx_d           = '0;
            woken_d         = '0;
            pick_ctrl.clear = 1'b1;
            state_d         = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // One slot per cycle: wake it if due, write back its order, and
        // offer it to the tracker if it is ready with work left. The next
        // slot is read in the same cycle, so reads never meet the write.
        mem_re = !last_slot;
        if (wake) begin
          mem_we         = 1'b1;
          mem_waddr      = idx_q;
          mem_wdata      = scan_entry;
          ready_d[idx_q] = 1'b1;
          woken_d        = woken_q + CNT_W'(1);
        end
        pick_ctrl.cand = slot_used && (ready_q[idx_q] || wake) && (rd_entry.left != '0);
        if (last_slot) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      ST_FINISH: begin
        // Run the chosen task, if any, for one unit, then advance the clock unless it is at its maximum.
        rsp_d.kind     = FUNC_TICK;
        rsp_d.accepted = 1'b0;
        rsp_d.idle     = !pick_found;
        rsp_d.now      = clock_q;
        rsp_d.task_id  = '0;
        rsp_d.left     = '0;
        rsp_d.consumed = '0;
        if (pick_found) begin
          mem_we             = 1'b1;
          mem_waddr          = pick_slot;
          mem_wdata          = pick_entry;
          mem_wdata.left     = pick_entry.left - WORK_W'(1);
          mem_wdata.consumed = pick_entry.consumed + WORK_W'(1);
          rsp_d.task_id      = TASK_ID_W'(pick_slot);
          rsp_d.left         = pick_entry.left - WORK_W'(1);
          rsp_d.consumed     = pick_entry.consumed + WORK_W'(1);
        end
        next_order_d = order_sum[ORDER_W] ? ORDER_MAX : order_sum[ORDER_W-1:0];
        if (clock_q != CLOCK_MAX) begin
          clock_d = clock_q + TIME_W'(1);
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      used_cnt_q   <= '0;
      woken_q      <= '0;
      ready_q      <= '0;
      clock_q      <= '0;
      next_order_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      used_cnt_q   <= used_cnt_d;
      woken_q      <= woken_d;
      ready_q      <= ready_d;
      clock_q      <= clock_d;
      next_order_q <= next_order_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
